### rtl/rmgb_pkg.sv
// Shared types and constants for the rotated mono glyph blitter.
// Fixed field widths, command codes and the store control struct; no dependencies.
package rmgb_pkg;

  localparam int X_W       = 9;
  localparam int Y_W       = 10;
  localparam int COL_W     = X_W + 1;
  localparam int ROW_W     = 24;
  localparam int BADDR_W   = 16;
  localparam int GW_W      = 5;
  localparam int DATA_W    = 8;
  localparam int CMD_W     = 2;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 8;

  localparam logic [GW_W-1:0]   GW_RESET = 5'd8;
  localparam logic [DATA_W-1:0] WHITE    = 8'hFF;
  localparam logic [DATA_W-1:0] TOP_BIT  = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_GLYPH = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

### rtl/rotated_mono_glyph_blitter_top.sv
// Rotated mono glyph blitter on rmgb_pkg and rmgb_store; one pixel per cycle through the store.
// A new request is taken only after the result of the last one has been loaded into the output
// register. Off-store pixels are not written and, like out-of-range byte reads, flag a drop.
// Reset (async, active low) clears all RES_X*RES_Y/8 bytes of the store to white
// (36000 by default); no request is taken until then. Config writes are taken at any time.
module rotated_mono_glyph_blitter_top #(
  parameter int RES_X           = 480,
  parameter int RES_Y           = 600,
  parameter int MAX_GLYPH_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config: glyph_width
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rmgb_pkg::GW_W-1:0]       cfg_data_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // x_pos[8:0], y_pos[18:9], row_bits[42:19], colour[43], byte_addr[59:44], zero pad
  input  logic [rmgb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [rmgb_pkg::CMD_W-1:0]      s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_data[7:0]
  output logic [rmgb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // dropped[0]
  output logic                            m_axis_tuser
);
  import rmgb_pkg::*;

  localparam int STORE_BYTES = (RES_X * RES_Y) / 8;
  localparam int AW          = $clog2(STORE_BYTES);
  // bound on the magnitude of the rotated bit index, plus a sign bit
  localparam int BMAX        = (RES_X + 535) * RES_Y + RES_Y + 1024;
  localparam int BW          = $clog2(BMAX + 1) + 1;
  localparam int J_W         = $clog2(MAX_GLYPH_WIDTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_READ   = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // request fields
  cmd_e               in_cmd;
  logic [X_W-1:0]     in_x;
  logic [Y_W-1:0]     in_y;
  logic [ROW_W-1:0]   in_row;
  logic               in_colour;
  logic [BADDR_W-1:0] in_addr;
  logic               s_accept;

  // held request
  logic [X_W-1:0]     x_q;
  logic [Y_W-1:0]     y_q;
  logic [BADDR_W-1:0] addr_q;
  logic [ROW_W-1:0]   rowsh_q;
  logic [J_W-1:0]     n_q;
  logic [J_W-1:0]     j_q;
  logic               drop_q;
  logic [DATA_W-1:0]  res_data_q;

  logic [GW_W-1:0]    gw_q;
  logic [GW_W-1:0]    w_clamp;
  logic [ROW_W-1:0]   row_align;

  // pixel pipeline
  logic                 issue;
  logic [COL_W-1:0]     col;
  logic signed [BW-1:0] diff_x, diff_y, b_calc;
  logic                 s1_valid_q;
  logic signed [BW-1:0] s1_b_q;
  logic                 s1_ink_q;
  logic                 s1_in_range;
  logic [DATA_W-1:0]    s1_mask;
  logic                 s2_valid_q;
  logic [AW-1:0]        s2_addr_q;
  logic [DATA_W-1:0]    s2_mask_q;
  logic                 s2_ink_q;

  // store access
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      rd_addr;
  logic [DATA_W-1:0]  rdata;
  logic [DATA_W-1:0]  wdata;
  logic               st_ready;
  logic               addr_in_range;

  // output register
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_drop_q;
  logic               out_load;

  assign in_cmd    = cmd_e'(s_axis_tuser);
  assign in_x      = s_axis_tdata[8:0];
  assign in_y      = s_axis_tdata[18:9];
  assign in_row    = s_axis_tdata[42:19];
  assign in_colour = s_axis_tdata[43];
  assign in_addr   = s_axis_tdata[59:44];

  assign s_axis_tready = (state_q == ST_IDLE) & st_ready;
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // clamp the width, then left-align the used bytes so pixel j sits at bit 23-j
  assign w_clamp = (gw_q > GW_W'(MAX_GLYPH_WIDTH)) ? GW_W'(MAX_GLYPH_WIDTH) : gw_q;
  always_comb begin
    priority if (w_clamp <= GW_W'(8)) begin
      row_align = {in_row[7:0], 16'b0};
    end else if (w_clamp <= GW_W'(16)) begin
      row_align = {in_row[15:0], 8'b0};
    end else begin
      row_align = in_row;
    end
  end

  // stage 0: rotated bit index of pixel j
  assign issue  = (state_q == ST_RUN) && (j_q < n_q);
  assign col    = COL_W'(x_q) + COL_W'(j_q);
  assign diff_x = $signed(BW'(RES_X)) - $signed(BW'(col));
  assign diff_y = $signed(BW'(RES_Y)) - $signed(BW'(y_q));
  assign b_calc = diff_x * $signed(BW'(RES_Y)) + diff_y;

  // stage 1: range check, read the byte; pixels of one row always hit distinct bytes
  assign s1_in_range = ~s1_b_q[BW-1] &&
                       (32'(s1_b_q[BW-2:3]) < 32'(STORE_BYTES));
  assign s1_mask     = TOP_BIT >> s1_b_q[2:0];

  assign addr_in_range = 32'(addr_q) < 32'(STORE_BYTES);

  always_comb begin
    mem_ctl.rd_en = (s1_valid_q & s1_in_range) | ((state_q == ST_READ) & addr_in_range);
    mem_ctl.wr_en = s2_valid_q;
    rd_addr       = (state_q == ST_READ) ? AW'(addr_q) : s1_b_q[AW+2:3];
  end

  // stage 2: modify and write back
  assign wdata = s2_ink_q ? (rdata & ~s2_mask_q) : (rdata | s2_mask_q);

  rmgb_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mem_ctl),
    .waddr_i (s2_addr_q),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata),
    .ready_o (st_ready)
  );

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          unique case (in_cmd)
            CMD_GLYPH, CMD_PIXEL: state_d = ST_RUN;
            CMD_READ:             state_d = ST_READ;
            CMD_NOP:              state_d = ST_RESP;
            default:              state_d = ST_RESP;
          endcase
        end
      end
      ST_RUN: begin
        // wait until the last pixel has left the pipeline
        if (!issue && !s1_valid_q && !s2_valid_q) begin
          state_d = ST_RESP;
        end
      end
      ST_READ:   state_d = addr_in_range ? ST_RDWAIT : ST_RESP;
      ST_RDWAIT: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gw_q        <= GW_RESET;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q & s1_in_range;
      if (cfg_valid_i) begin
        gw_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request hold, pipeline payload and result payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      x_q        <= in_x;
      y_q        <= in_y;
      addr_q     <= in_addr;
      j_q        <= '0;
      drop_q     <= 1'b0;
      res_data_q <= '0;
      unique case (in_cmd)
        CMD_GLYPH: begin
          n_q     <= J_W'(w_clamp);
          rowsh_q <= row_align;
        end
        CMD_PIXEL: begin
          n_q     <= J_W'(1);
          rowsh_q <= {in_colour, {(ROW_W-1){1'b0}}};
        end
        default: begin
          n_q     <= '0;
          rowsh_q <= '0;
        end
      endcase
    end else begin
      if (issue) begin
        j_q     <= j_q + J_W'(1);
        rowsh_q <= rowsh_q << 1;
      end
      // flag out-of-store pixels and reads, keep writing the rest
      if ((s1_valid_q && !s1_in_range) || ((state_q == ST_READ) && !addr_in_range)) begin
        drop_q <= 1'b1;
      end
      if (state_q == ST_RDWAIT) begin
        res_data_q <= rdata;
      end
    end

    s1_b_q    <= b_calc;
    s1_ink_q  <= rowsh_q[ROW_W-1];
    s2_addr_q <= s1_b_q[AW+2:3];
    s2_mask_q <= s1_mask;
    s2_ink_q  <= s1_ink_q;

    if (out_load) begin
      out_data_q <= res_data_q;
      out_drop_q <= drop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_drop_q;

  // write-back and the next read never target the same byte
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && mem_ctl.rd_en) |-> (s2_addr_q != rd_addr))
    else $error("read and write-back hit the same byte");

  // the pixel pipeline is drained whenever a new request can be taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_valid_q && !s2_valid_q))
    else $error("pixel pipeline busy in idle");

  // a dropped result never carries read data
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("dropped result with nonzero data");

endmodule

### rtl/rmgb_store.sv
// Frame store: byte memory with one write and one registered read port.
// Sweeps every byte to white after reset. Depends on rmgb_pkg.
module rmgb_store #(
  parameter int DEPTH = 36000,
  parameter int AW    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rmgb_pkg::mem_ctl_t           ctl_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [rmgb_pkg::DATA_W-1:0]  wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [rmgb_pkg::DATA_W-1:0]  rdata_o,
  output logic                         ready_o
);
  import rmgb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              clr_busy_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              wr;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  // clear sweep owns the write port until it is done
  assign wr = clr_busy_q | ctl_i.wr_en;
  assign wa = clr_busy_q ? clr_cnt_q : waddr_i;
  assign wd = clr_busy_q ? WHITE : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[wa] <= wd;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = ~clr_busy_q;

endmodule

### dv/rotated_mono_glyph_blitter_top_tb.sv
// Self-checking testbench for rotated_mono_glyph_blitter_top: drives glyph, pixel, read and unused
// command requests with random idling on both streams and checks every result against a local copy
// of the rotated frame store. Depends on rmgb_pkg and the RTL of the block.
module rotated_mono_glyph_blitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmgb_pkg::*;

  localparam int RES_X       = 480;
  localparam int RES_Y       = 600;
  localparam int MAX_GW      = 24;
  localparam int STORE_BYTES = RES_X * RES_Y / 8;
  localparam int TOUCH_DEPTH = 64;

  // One request as the block sees it on the slave stream.
  typedef struct packed {
    cmd_e                cmd;
    logic [X_W-1:0]      x_pos;
    logic [Y_W-1:0]      y_pos;
    logic [ROW_W-1:0]    row_bits;
    logic                colour;
    logic [BADDR_W-1:0]  byte_addr;
  } blit_req_t;

  // One result as it should leave the master stream.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              dropped;
  } blit_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [GW_W-1:0]      cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [CMD_W-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  // Local copy of the rotated frame store and of the glyph width register.
  logic [DATA_W-1:0] frame_copy [STORE_BYTES];
  logic [GW_W-1:0]   glyph_width_copy = GW_RESET;

  // Results owed by the block, oldest first.
  blit_result_t owed_results [$];
  // Recently written byte indexes, so that reads land on live data.
  int           touched_bytes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;

  rotated_mono_glyph_blitter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: covers the clearing pass after reset plus every request at its slowest,
  // with the stalls of both streams, several times over.
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  // Map a pixel to its byte in the rotated store; negative or past the end means off-store.
  function automatic int pixel_byte(int col, int line);
    int bit_ix;
    bit_ix = (RES_X - col) * RES_Y + (RES_Y - line);
    if (bit_ix < 0) begin
      return -1;
    end
    return bit_ix / 8;
  endfunction

  // Write one pixel into the local store; return 1 when it falls off the store.
  function automatic bit plot_pixel(int col, int line, bit ink);
    int                bit_ix;
    int                byte_ix;
    logic [DATA_W-1:0] mask;
    bit_ix = (RES_X - col) * RES_Y + (RES_Y - line);
    if (bit_ix < 0) begin
      return 1'b1;
    end
    byte_ix = bit_ix / 8;
    if (byte_ix >= STORE_BYTES) begin
      return 1'b1;
    end
    // Bits are stored MSB first within each byte.
    mask = TOP_BIT >> (bit_ix % 8);
    if (ink) begin
      frame_copy[byte_ix] = frame_copy[byte_ix] & ~mask;
    end else begin
      frame_copy[byte_ix] = frame_copy[byte_ix] | mask;
    end
    touched_bytes.push_back(byte_ix);
    if (touched_bytes.size() > TOUCH_DEPTH) begin
      void'(touched_bytes.pop_front());
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the local store and return the result it owes.
  function automatic blit_result_t blit_outcome(blit_req_t req);
    blit_result_t res;
    int           width;
    int           row_span;
    res = '0;
    case (req.cmd)
      CMD_GLYPH: begin
        // Clamp oversized widths; the row is left aligned in whole bytes.
        width    = (glyph_width_copy > MAX_GW) ? MAX_GW : int'(glyph_width_copy);
        row_span = ((width + 7) / 8) * 8;
        for (int j = 0; j < width; j++) begin
          if (plot_pixel(int'(req.x_pos) + j, int'(req.y_pos), req.row_bits[row_span-1-j])) begin
            res.dropped = 1'b1;
          end
        end
      end
      CMD_PIXEL: begin
        res.dropped = plot_pixel(int'(req.x_pos), int'(req.y_pos), req.colour);
      end
      CMD_READ: begin
        if (req.byte_addr < STORE_BYTES) begin
          res.read_data = frame_copy[req.byte_addr];
        end else begin
          res.dropped = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic blit_req_t make_req(cmd_e cmd, int x, int y, logic [ROW_W-1:0] row,
                                         logic colour, int addr);
    blit_req_t req;
    req.cmd       = cmd;
    req.x_pos     = x[X_W-1:0];
    req.y_pos     = y[Y_W-1:0];
    req.row_bits  = row;
    req.colour    = colour;
    req.byte_addr = addr[BADDR_W-1:0];
    return req;
  endfunction

  // Mostly in-range coordinates with random content; now and then the full field range.
  function automatic blit_req_t random_req();
    blit_req_t req;
    int        sel;
    int        pick;
    sel = $urandom_range(99);
    if (sel < 40) begin
      req.cmd = CMD_GLYPH;
    end else if (sel < 65) begin
      req.cmd = CMD_PIXEL;
    end else if (sel < 95) begin
      req.cmd = CMD_READ;
    end else begin
      req.cmd = CMD_NOP;
    end
    req.x_pos    = ($urandom_range(9) == 0) ? X_W'($urandom) : X_W'($urandom_range(RES_X));
    req.y_pos    = ($urandom_range(9) == 0) ? Y_W'($urandom) : Y_W'($urandom_range(RES_Y));
    req.row_bits = ROW_W'($urandom);
    req.colour   = 1'($urandom);
    pick         = $urandom_range(99);
    if (pick < 50 && touched_bytes.size() != 0) begin
      req.byte_addr = BADDR_W'(touched_bytes[$urandom_range(touched_bytes.size() - 1)]);
    end else if (pick < 85) begin
      req.byte_addr = BADDR_W'($urandom_range(STORE_BYTES - 1));
    end else begin
      req.byte_addr = BADDR_W'($urandom);
    end
    return req;
  endfunction

  // Send one request; valid stays high afterwards unless the next call opens a gap.
  task automatic send_request(blit_req_t req);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      // Mix short and long gaps so they land on every stage of a glyph row.
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 30 : 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.cmd;
    s_axis_tdata  <= {{(S_TDATA_W - 60){1'b0}}, req.byte_addr, req.colour, req.row_bits,
                      req.y_pos, req.x_pos};
    do @(posedge clk_i); while (!s_axis_tready);
    owed_results.push_back(blit_outcome(req));
  endtask

  // Drop valid and hold until every owed result has left the block, then let it settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_glyph_width(logic [GW_W-1:0] width);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= width;
    do @(posedge clk_i); while (!cfg_ready_o);
    glyph_width_copy = width;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receive side: check each result against the oldest owed one, then pick next ready.
  always @(posedge clk_i) begin
    blit_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $error("result with no request pending: read_data %0h dropped %0b",
               m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (m_axis_tdata !== want.read_data) begin
          $error("read_data mismatch: expected %0h, actual %0h", want.read_data, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== want.dropped) begin
          $error("dropped mismatch: expected %0b, actual %0b", want.dropped, m_axis_tuser);
          error_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The store must come up white after the clearing pass; probe both ends and past them.
  task automatic test_reset_contents();
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, 0));
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, STORE_BYTES - 1));
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, STORE_BYTES));
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, 16'hFFFF));
  endtask

  // Corners of the rotated mapping, off-store pixels and the unused command.
  task automatic test_store_edges();
    // Rightmost column, bottom line: bit 0 of the store.
    send_request(make_req(CMD_PIXEL, RES_X, RES_Y, '0, 1'b1, 0));
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, 0));
    // Column 0, line 0 lands past the end.
    send_request(make_req(CMD_PIXEL, 0, 0, '0, 1'b1, 0));
    // Largest field values: far outside on both axes.
    send_request(make_req(CMD_PIXEL, 511, 1023, '0, 1'b1, 0));
    // Glyph row from column 0: first pixel off the store, the rest written.
    send_request(make_req(CMD_GLYPH, 0, 300, 24'hFFFF5A, 1'b0, 0));
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, pixel_byte(1, 300)));
    // Glyph row running past the last column: tail pixels go negative.
    send_request(make_req(CMD_GLYPH, RES_X - 5, 5, 24'h0000C3, 1'b0, 0));
    // Paper over ink restores the bit.
    send_request(make_req(CMD_PIXEL, RES_X, RES_Y, '0, 1'b0, 0));
    send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, 0));
    send_request(make_req(CMD_NOP, 511, 1023, 24'hFFFFFF, 1'b1, 16'hFFFF));
  endtask

  // Zero width, one pixel, full width and an oversized value that must clamp.
  task automatic test_glyph_widths();
    logic [GW_W-1:0] widths [4] = '{5'd0, 5'd1, 5'd24, 5'd31};
    foreach (widths[i]) begin
      drain_results();
      write_glyph_width(widths[i]);
      send_request(make_req(CMD_GLYPH, (i == 0) ? 0 : 100, 200 + i, 24'hFFFFFF, 1'b0, 0));
      send_request(make_req(CMD_READ, 0, 0, '0, 1'b0, pixel_byte(100, 200 + i)));
    end
  endtask

  // One idling profile; the width changes at the start and again after a full drain midway.
  task automatic test_random_traffic(int send_pct, int recv_pct, int count,
                                     logic [GW_W-1:0] first_width, logic [GW_W-1:0] second_width);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    drain_results();
    write_glyph_width(first_width);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain_results();
        write_glyph_width(second_width);
      end
      send_request(random_req());
    end
  endtask

  initial begin
    foreach (frame_copy[i]) begin
      frame_copy[i] = WHITE;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_store_edges();
    test_glyph_widths();
    test_random_traffic(21, 80, 400, 5'd24, 5'd1);
    test_random_traffic(80, 21, 400, 5'd31, 5'd13);
    test_random_traffic(0, 0, 400, 5'd8, GW_W'($urandom_range(2, 23)));

    drain_results();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
